// File: hw/rtl/text_console_cursor_engine_defines.svh
// ----------------------------------------------------------------------------
// Text console cursor engine - assertion macros
// Shared concurrent assertion forms for the cursor engine RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, gated by the active-low reset.
`define TCCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine - package
// Operation codes, character codes and the types shared by the engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // cell operation codes
    localparam logic [1:0] OP_DRAW         = 2'd0;
    localparam logic [1:0] OP_CLEAR_CELL   = 2'd1;
    localparam logic [1:0] OP_SCROLL       = 2'd2;
    localparam logic [1:0] OP_CLEAR_SCREEN = 2'd3;

    // control characters
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam logic [6:0] GLYPH_SUBST = 7'h3F;
    localparam logic [6:0] GLYPH_SPACE = 7'h20;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        K_CHAR      = 3'd0,
        K_CLEAR     = 3'd1,
        K_NEWLINE   = 3'd2,
        K_RETURN    = 3'd3,
        K_TAB       = 3'd4,
        K_BACKSPACE = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] glyph;
    } entry_t;

    // effective geometry, zero already mapped to one
    typedef struct packed {
        logic [7:0] cols;
        logic [6:0] rows;
    } geom_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] column;
        logic [6:0] row;
        logic [6:0] glyph;
        logic       last;
    } cell_op_t;

endpackage

// File: hw/rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// Text console cursor engine - top level
// Turns characters and clear commands into display cell operations.
//
//   Port group   Dir   Moves
//   s_*          in    one character or clear command per beat
//   m_*          out   one cell operation per beat, tlast on the final one
//   APB          in    columns (0x0) and text_rows (0x4) registers
//
// Plain characters, newline, return, backspace and clear are handled in the
// idle state; a draw that scrolls goes on to the scroll state. A tab leaves
// idle for the divide and remainder states, then draws its spaces, plus a
// scroll where needed. The two-entry queue lets input beats land while the
// sequencer is busy. Reset homes the cursor and loads 80 columns by 25 rows;
// the output register holds its beat while m_tready is low.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_defines.svh"

module text_console_cursor_engine #(
    parameter int TAB_STOP = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,    // [0] command
    input  logic [7:0]  s_tdata,    // [7:0] char_code

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,    // [1:0] op
    output logic [23:0] m_tdata,    // [7:0] cell_column, [14:8] cell_row, [21:15] glyph
    output logic        m_tlast,    // last

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]          columns_reg;
    logic [6:0]          text_rows_reg;
    logic                cfg_write;
    tcce_pkg::geom_t     geom;
    logic                queue_full;
    logic                push_valid;
    tcce_pkg::entry_t    push_entry;
    logic                pop;
    logic                head_valid;
    tcce_pkg::entry_t    head_entry;
    tcce_pkg::cell_op_t  m_op;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {25'd0, text_rows_reg} : {24'd0, columns_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg   <= 8'd80;
            text_rows_reg <= 7'd25;
        end else if (cfg_write) begin
            if (paddr[2]) begin
                text_rows_reg <= pwdata[6:0];
            end else begin
                columns_reg <= pwdata[7:0];
            end
        end
    end

    // zero geometry acts as one
    assign geom.cols = (columns_reg == '0) ? 8'd1 : columns_reg;
    assign geom.rows = (text_rows_reg == '0) ? 7'd1 : text_rows_reg;

    tcce_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    tcce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    tcce_back #(
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .geom       (geom),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_op       (m_op)
    );

    assign m_tuser = m_op.op;
    assign m_tlast = m_op.last;
    assign m_tdata = {2'b00, m_op.glyph, m_op.row, m_op.column};

    `TCCE_ASSERT_NOW(a_glyph_only_on_draw, aclk, aresetn,
        m_tvalid && (m_tuser != tcce_pkg::OP_DRAW),
        m_tdata[21:15] == 7'd0, "glyph set on a non-draw operation")

    `TCCE_ASSERT_NOW(a_screen_ops_no_cell, aclk, aresetn,
        m_tvalid && ((m_tuser == tcce_pkg::OP_SCROLL) ||
                     (m_tuser == tcce_pkg::OP_CLEAR_SCREEN)),
        m_tdata[14:0] == 15'd0, "cell position set on a screen-wide operation")

    `TCCE_ASSERT_NOW(a_clear_screen_last, aclk, aresetn,
        m_tvalid && (m_tuser == tcce_pkg::OP_CLEAR_SCREEN),
        m_tlast, "clear screen is not the final operation")

    `TCCE_ASSERT_NEXT(a_full_queue_stalls, aclk, aresetn,
        s_tvalid && s_tready && queue_full,
        1'b0, "input beat taken while the queue was full")

endmodule

// File: hw/rtl/tcce_queue.sv
// ----------------------------------------------------------------------------
// Text console cursor engine - command queue
// Short register queue between the classifier and the cursor sequencer.
// ----------------------------------------------------------------------------
module tcce_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  tcce_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tcce_pkg::entry_t  head_entry
);

    localparam int PTR_W = (tcce_pkg::QUEUE_DEPTH > 1) ? $clog2(tcce_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tcce_pkg::QUEUE_DEPTH + 1);

    tcce_pkg::entry_t  mem_reg [tcce_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push_ok;
    logic              pop_ok;

    assign full       = (count_reg == CNT_W'(tcce_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign push_ok    = push_valid && !full;
    assign pop_ok     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok && !push_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/tcce_front.sv
// ----------------------------------------------------------------------------
// Text console cursor engine - front end
// Accepts input beats and sorts them into command kinds for the queue.
// ----------------------------------------------------------------------------
module tcce_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,      // [0] command
    input  logic [7:0]        s_tdata,      // [7:0] char_code
    input  logic              queue_full,
    output logic              push_valid,
    output tcce_pkg::entry_t  push_entry
);

    assign s_tready   = !queue_full;
    assign push_valid = s_tvalid;

    always_comb begin
        push_entry.glyph = s_tdata[7] ? tcce_pkg::GLYPH_SUBST : s_tdata[6:0];
        if (s_tuser) begin
            push_entry.kind = tcce_pkg::K_CLEAR;
        end else begin
            unique case (s_tdata)
                tcce_pkg::CH_NEWLINE:   push_entry.kind = tcce_pkg::K_NEWLINE;
                tcce_pkg::CH_RETURN:    push_entry.kind = tcce_pkg::K_RETURN;
                tcce_pkg::CH_TAB:       push_entry.kind = tcce_pkg::K_TAB;
                tcce_pkg::CH_BACKSPACE: push_entry.kind = tcce_pkg::K_BACKSPACE;
                default:                push_entry.kind = tcce_pkg::K_CHAR;
            endcase
        end
    end

endmodule

// File: hw/rtl/tcce_back.sv
// ----------------------------------------------------------------------------
// Text console cursor engine - back end
// Holds the cursor, sequences cell operations and registers the result beat.
// ----------------------------------------------------------------------------
module tcce_back #(
    parameter int TAB_STOP = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tcce_pkg::geom_t     geom,
    input  logic                head_valid,
    input  tcce_pkg::entry_t    head_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tcce_pkg::cell_op_t  m_op
);

    // column / TAB_STOP through a reciprocal, exact for 8-bit columns
    localparam int          DIV_SHIFT = 16;
    localparam int unsigned RECIP     = ((2 ** DIV_SHIFT) + TAB_STOP - 1) / TAB_STOP;
    localparam int          PROD_W    = 8 + DIV_SHIFT;
    localparam int          CNT_W     = $clog2(TAB_STOP + 1);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_TAB_DIV  = 5'b00010,
        ST_TAB_REM  = 5'b00100,
        ST_TAB_DRAW = 5'b01000,
        ST_SCROLL   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [7:0]          col_reg, col_next;
    logic [6:0]          row_reg, row_next;
    logic [7:0]          quot_reg, quot_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic                out_valid_reg, out_valid_next;
    tcce_pkg::cell_op_t  out_reg, out_next;

    logic                out_free;
    logic [8:0]          col_inc;
    logic                wrap;
    logic [7:0]          row_inc;
    logic                row_over;
    logic [6:0]          row_last;
    logic [PROD_W-1:0]   recip_prod;
    logic [12:0]         back_prod;
    logic [7:0]          rem;
    logic [CNT_W-1:0]    tab_left;
    logic                emit;
    tcce_pkg::cell_op_t  emit_op;
    logic                do_draw;
    logic [6:0]          draw_glyph;
    logic                draw_stop;

    assign out_free   = !out_valid_reg || m_tready;
    assign col_inc    = {1'b0, col_reg} + 9'd1;
    assign wrap       = (col_inc >= {1'b0, geom.cols});
    assign row_inc    = {1'b0, row_reg} + 8'd1;
    assign row_over   = (row_inc >= {1'b0, geom.rows});
    assign row_last   = geom.rows - 7'd1;
    assign recip_prod = PROD_W'(col_reg) * PROD_W'(RECIP);
    assign back_prod  = 13'(quot_reg) * 13'(TAB_STOP);
    assign rem        = col_reg - back_prod[7:0];
    assign tab_left   = CNT_W'(9'(TAB_STOP) - {1'b0, rem});

    assign m_tvalid = out_valid_reg;
    assign m_op     = out_reg;

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        quot_next  = quot_reg;
        left_next  = left_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_op    = '0;
        do_draw    = 1'b0;
        draw_glyph = head_entry.glyph;
        draw_stop  = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid && out_free) begin
                    pop = 1'b1;
                    unique case (head_entry.kind)
                        tcce_pkg::K_CLEAR: begin
                            emit         = 1'b1;
                            emit_op.op   = tcce_pkg::OP_CLEAR_SCREEN;
                            emit_op.last = 1'b1;
                            col_next     = '0;
                            row_next     = '0;
                        end
                        tcce_pkg::K_NEWLINE: begin
                            col_next = '0;
                            if (row_over) begin
                                emit         = 1'b1;
                                emit_op.op   = tcce_pkg::OP_SCROLL;
                                emit_op.last = 1'b1;
                                row_next     = row_last;
                            end else begin
                                row_next = row_inc[6:0];
                            end
                        end
                        tcce_pkg::K_RETURN: begin
                            col_next = '0;
                        end
                        tcce_pkg::K_TAB: begin
                            state_next = ST_TAB_DIV;
                        end
                        tcce_pkg::K_BACKSPACE: begin
                            if (col_reg != '0) begin
                                col_next       = col_reg - 8'd1;
                                emit           = 1'b1;
                                emit_op.op     = tcce_pkg::OP_CLEAR_CELL;
                                emit_op.column = col_reg - 8'd1;
                                emit_op.row    = row_reg;
                                emit_op.last   = 1'b1;
                            end else if (row_reg != '0) begin
                                // wrap back to the end of the previous line
                                col_next       = geom.cols - 8'd1;
                                row_next       = row_reg - 7'd1;
                                emit           = 1'b1;
                                emit_op.op     = tcce_pkg::OP_CLEAR_CELL;
                                emit_op.column = geom.cols - 8'd1;
                                emit_op.row    = row_reg - 7'd1;
                                emit_op.last   = 1'b1;
                            end
                        end
                        tcce_pkg::K_CHAR: begin
                            do_draw = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TAB_DIV: begin
                quot_next  = recip_prod[PROD_W-1:DIV_SHIFT];
                state_next = ST_TAB_REM;
            end
            ST_TAB_REM: begin
                left_next  = tab_left;
                state_next = ST_TAB_DRAW;
            end
            ST_TAB_DRAW: begin
                if (out_free) begin
                    do_draw    = 1'b1;
                    draw_glyph = tcce_pkg::GLYPH_SPACE;
                    draw_stop  = (left_reg == CNT_W'(1));
                    left_next  = left_reg - 1'b1;
                end
            end
            ST_SCROLL: begin
                if (out_free) begin
                    emit         = 1'b1;
                    emit_op.op   = tcce_pkg::OP_SCROLL;
                    emit_op.last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // draw at the cursor, then advance with wrap and scroll
        if (do_draw) begin
            emit           = 1'b1;
            emit_op.op     = tcce_pkg::OP_DRAW;
            emit_op.column = col_reg;
            emit_op.row    = row_reg;
            emit_op.glyph  = draw_glyph;
            if (wrap) begin
                col_next = '0;
                if (row_over) begin
                    row_next     = row_last;
                    emit_op.last = 1'b0;
                    state_next   = ST_SCROLL;
                end else begin
                    row_next     = row_inc[6:0];
                    emit_op.last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end else begin
                col_next     = col_inc[7:0];
                emit_op.last = draw_stop;
                state_next   = draw_stop ? ST_IDLE : state_reg;
            end
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_next       = emit_op;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

endmodule
